### hw/rtl/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared types and constants for the top-k min-heap selector.
// ----------------------------------------------------------------------------
`default_nettype none
package tkh_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned TagW   = 24;
  localparam int unsigned CountW = 10;
  localparam int unsigned KReset = 50;

  localparam logic ActOffer = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [ValueW-1:0] candidate_value;
    logic [TagW-1:0]          candidate_start;
    logic [TagW-1:0]          candidate_end;
  } tkh_in_t;

  typedef struct packed {
    logic                     accepted;
    logic [CountW-1:0]        entry_count;
    logic signed [ValueW-1:0] threshold_value;
  } tkh_out_t;

  // Heap entry as stored in memory
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [TagW-1:0]          start;
    logic [TagW-1:0]          stop;
  } tkh_entry_t;

  // Classified request passed from the front to the back
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PUSH    = 2'd1,
    OP_REPLACE = 2'd2,
    OP_CHECK   = 2'd3
  } tkh_op_t;

  typedef struct packed {
    tkh_op_t    op;
    tkh_entry_t cand;
  } tkh_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/top_k_min_heap_selector.sv
// ----------------------------------------------------------------------------
// top_k_min_heap_selector
// Keeps the k largest (value, start, end) candidates in a binary min-heap.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake    | Payload
// in_     | input     | valid/stall  | tkh_in_t
// out_    | output    | valid/stall  | tkh_out_t
// cfg_    | input     | valid/ready  | active_k (10 bits)
//
// Clear and rejects go straight to the result; a push walks the sift-up a level
// at a time; a replace walks the sift-down and then the sift-up, its pace set
// by the single read port of the heap memory.
// Synchronous active-low reset empties the heap; memory is not cleared.
// A two-entry queue lets input be taken while the heap walk or output stalls.
// Configuration is taken only while nothing is queued or in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module top_k_min_heap_selector import tkh_pkg::*; #(
  parameter int unsigned HEAP_CAPACITY = 512
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  tkh_in_t                in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tkh_out_t               out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CountW-1:0] cfg_data
);

  logic [CountW-1:0] k_r;
  logic [CountW-1:0] eff_k;
  logic     q_valid, q_pop, busy;
  tkh_cmd_t q_cmd;

  // Accept a new k only while the pipeline is empty
  assign cfg_ready = !busy && !q_valid;

  // Hold the configured k
  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= CountW'(KReset);
    else if (cfg_valid && cfg_ready) k_r <= cfg_data;
  end

  // k of zero acts as one
  assign eff_k = (k_r == '0) ? CountW'(1) : k_r;

  tkh_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_pop, .q_valid, .q_cmd
  );

  tkh_back #(.HEAP_CAPACITY(HEAP_CAPACITY)) u_back (
    .clk, .rst_n, .eff_k, .q_valid, .q_cmd, .q_pop, .busy,
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

### hw/rtl/tkh_front.sv
// ----------------------------------------------------------------------------
// tkh_front
// Accepts requests, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tkh_front import tkh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  tkh_in_t       in_data,
  input  wire logic     q_pop,
  output logic          q_valid,
  output tkh_cmd_t      q_cmd
);

  tkh_cmd_t   q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  tkh_cmd_t   cmd;

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // Classify: the back decides push vs. replace from its own count
  always_comb begin
    cmd.cand.value = in_data.candidate_value;
    cmd.cand.start = in_data.candidate_start;
    cmd.cand.stop  = in_data.candidate_end;
    cmd.op         = (in_data.action == ActClear) ? OP_CLEAR : OP_CHECK;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tkh_back.sv
// ----------------------------------------------------------------------------
// tkh_back
// Carries out heap operations with one memory: a replace sifts down then up; a push sifts up only.
// ----------------------------------------------------------------------------
`default_nettype none
module tkh_back import tkh_pkg::*; #(
  parameter int unsigned HEAP_CAPACITY = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [CountW-1:0] eff_k,
  input  wire logic        q_valid,
  input  tkh_cmd_t         q_cmd,
  output logic             q_pop,
  output logic             busy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tkh_out_t         out_data
);

  localparam int unsigned AW = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned CW = AW;
  localparam int unsigned CmpW = (CW > CountW) ? CW : CountW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDLAST= 10'b0000000010,
    S_DNRDL = 10'b0000000100,
    S_DNRDR = 10'b0000001000,
    S_DNCMP = 10'b0000010000,
    S_UPRD  = 10'b0000100000,
    S_UPCMP = 10'b0001000000,
    S_DONE  = 10'b0010000000,
    S_DNWT  = 10'b0100000000,
    S_UPWT  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  tkh_entry_t mem [HEAP_CAPACITY+1];
  tkh_entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  tkh_entry_t    wr_data;
  logic          wr_en;

  logic [CW-1:0] count_r, count_nxt;
  tkh_entry_t    cand_r, cand_nxt;       // offered candidate
  tkh_entry_t    moving_r, moving_nxt;   // entry sifting down
  tkh_entry_t    left_r, left_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic signed [ValueW-1:0] root_r, root_nxt;
  logic          acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  tkh_out_t      out_r, out_nxt;

  logic [AW:0]   child;
  logic          k_reached;

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign child     = {pos_r, 1'b0};
  assign k_reached = (CmpW'(count_r) >= CmpW'(eff_k)) ||
                     (count_r >= CW'(HEAP_CAPACITY));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign busy      = (state_r != S_IDLE) || out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cand_nxt      = cand_r;
    moving_nxt    = moving_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    root_nxt      = root_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = moving_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop    = 1'b1;
          cand_nxt = q_cmd.cand;
          acc_nxt  = 1'b0;
          if (q_cmd.op == OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (!k_reached) begin
            // push: sift-up from new slot
            acc_nxt   = 1'b1;
            count_nxt = count_r + 1'b1;
            pos_nxt   = count_r + 1'b1;
            state_nxt = S_UPRD;
          end else if (q_cmd.cand.value > root_r) begin
            acc_nxt   = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = count_r;
            state_nxt = S_RDLAST;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RDLAST: begin
        state_nxt = S_DNWT;
      end
      S_DNWT: begin
        // last entry moves to root; count drops by one
        moving_nxt = rd_data_r;
        count_nxt  = count_r - 1'b1;
        pos_nxt    = AW'(1);
        state_nxt  = S_DNRDL;
      end
      S_DNRDL: begin
        if (child <= {1'b0, count_r}) begin
          rd_en     = 1'b1;
          rd_addr   = child[AW-1:0];
          state_nxt = S_DNRDR;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = moving_r;
          count_nxt = count_r + 1'b1;
          pos_nxt   = count_r + 1'b1;
          state_nxt = S_UPRD;
        end
      end
      S_DNRDR: begin
        left_nxt  = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = child[AW-1:0] + 1'b1;
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (child + 1'b1 <= {1'b0, count_r} && rd_data_r.value < left_r.value) begin
          if (rd_data_r.value >= moving_r.value) begin
            wr_en = 1'b1; wr_addr = pos_r; wr_data = moving_r;
            count_nxt = count_r + 1'b1; pos_nxt = count_r + 1'b1;
            state_nxt = S_UPRD;
          end else begin
            wr_en = 1'b1; wr_addr = pos_r; wr_data = rd_data_r;
            pos_nxt = child[AW-1:0] + 1'b1;
            state_nxt = S_DNRDL;
          end
        end else if (left_r.value >= moving_r.value) begin
          wr_en = 1'b1; wr_addr = pos_r; wr_data = moving_r;
          count_nxt = count_r + 1'b1; pos_nxt = count_r + 1'b1;
          state_nxt = S_UPRD;
        end else begin
          wr_en = 1'b1; wr_addr = pos_r; wr_data = left_r;
          pos_nxt = child[AW-1:0];
          state_nxt = S_DNRDL;
        end
      end
      S_UPRD: begin
        if (pos_r > AW'(1)) begin
          rd_en     = 1'b1;
          rd_addr   = pos_r >> 1;
          state_nxt = S_UPWT;
        end else begin
          wr_en = 1'b1; wr_addr = pos_r; wr_data = cand_r;
          root_nxt  = cand_r.value;
          state_nxt = S_DONE;
        end
      end
      S_UPWT: begin
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (rd_data_r.value <= cand_r.value) begin
          wr_en = 1'b1; wr_addr = pos_r; wr_data = cand_r;
          state_nxt = S_DONE;
        end else begin
          wr_en = 1'b1; wr_addr = pos_r; wr_data = rd_data_r;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UPRD;
        end
      end
      S_DONE: begin
        out_nxt.accepted        = acc_r;
        out_nxt.entry_count     = CountW'(count_r);
        out_nxt.threshold_value = (count_r == '0) ? '0 : root_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Track root on any write to slot one
    if (wr_en && wr_addr == AW'(1)) root_nxt = wr_data.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r   <= cand_nxt;
    moving_r <= moving_nxt;
    left_r   <= left_nxt;
    pos_r    <= pos_nxt;
    root_r   <= root_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-k min-heap selector: drives offers and
// clears, predicts each result with a local heap and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import tkh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity   = 512;
  localparam int WatchLimit = 20000;
  localparam int DrainWait  = 100;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tkh_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tkh_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CountW-1:0] cfg_data = '0;

  // Predictor state
  logic signed [ValueW-1:0] heap_val [1:Capacity];
  logic [TagW-1:0]          heap_start [1:Capacity];
  logic [TagW-1:0]          heap_end [1:Capacity];
  int                       heap_size;
  logic [CountW-1:0]        keep_k;

  // Ring of expected results, oldest at exp_rd
  tkh_out_t                 expect_mem [64];
  logic [5:0]               exp_wr = '0;
  logic [5:0]               exp_rd = '0;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  idle_ok = 1'b1;

  always #1 clk = ~clk;

  top_k_min_heap_selector i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Insert with sift-up, stop at first parent <= candidate
  function automatic void heap_push(logic signed [ValueW-1:0] v, logic [TagW-1:0] s,
                                    logic [TagW-1:0] e);
    int pos;
    int par;
    if (heap_size >= Capacity) return;
    heap_size++;
    pos = heap_size;
    while (pos > 1) begin
      par = pos / 2;
      if (heap_val[par] <= v) break;
      heap_val[pos] = heap_val[par];
      heap_start[pos] = heap_start[par];
      heap_end[pos] = heap_end[par];
      pos = par;
    end
    heap_val[pos] = v;
    heap_start[pos] = s;
    heap_end[pos] = e;
  endfunction

  // Remove root: move last entry up, sift down preferring strictly smaller right
  function automatic void heap_drop_root();
    int pos;
    int c;
    logic signed [ValueW-1:0] tv;
    logic [TagW-1:0] ts;
    logic [TagW-1:0] te;
    pos = 1;
    if (heap_size == 0) return;
    heap_val[1] = heap_val[heap_size];
    heap_start[1] = heap_start[heap_size];
    heap_end[1] = heap_end[heap_size];
    heap_size--;
    while (2 * pos <= heap_size) begin
      c = 2 * pos;
      if (c + 1 <= heap_size && heap_val[c+1] < heap_val[c]) c++;
      if (heap_val[c] >= heap_val[pos]) break;
      tv = heap_val[c]; heap_val[c] = heap_val[pos]; heap_val[pos] = tv;
      ts = heap_start[c]; heap_start[c] = heap_start[pos]; heap_start[pos] = ts;
      te = heap_end[c]; heap_end[c] = heap_end[pos]; heap_end[pos] = te;
      pos = c;
    end
  endfunction

  function automatic tkh_out_t predict_selection(tkh_in_t req);
    tkh_out_t r;
    int k;
    r = '0;
    k = keep_k;
    if (k < 1) k = 1;
    if (k > Capacity) k = Capacity;
    if (req.action == ActClear) begin
      heap_size = 0;
    end else if (heap_size < k) begin
      heap_push(req.candidate_value, req.candidate_start, req.candidate_end);
      r.accepted = 1'b1;
    end else if (req.candidate_value > heap_val[1]) begin
      heap_drop_root();
      heap_push(req.candidate_value, req.candidate_start, req.candidate_end);
      r.accepted = 1'b1;
    end
    r.entry_count = heap_size[CountW-1:0];
    r.threshold_value = heap_size > 0 ? heap_val[1] : '0;
    return r;
  endfunction

  // Watchdog: count cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout waiting for a request");
      $display("top_k_min_heap_selector regression: fail");
      $finish;
    end
  end

  // Result stall in random bursts
  always @(posedge clk) begin
    if (!idle_ok) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(0, 2) != 0);
    else out_stall <= ($urandom_range(0, 5) == 0);
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    tkh_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = expect_mem[exp_rd];
        exp_rd <= exp_rd + 1'b1;
        if (out_data.accepted !== want.accepted ||
            out_data.entry_count !== want.entry_count ||
            out_data.threshold_value !== want.threshold_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected acc=%0d cnt=%0d thr=%0d got acc=%0d cnt=%0d thr=%0d",
                     want.accepted, want.entry_count, want.threshold_value,
                     out_data.accepted, out_data.entry_count, out_data.threshold_value);
        end
      end
    end
  end

  // Valid stays high between back-to-back requests unless a random gap drops it; drain() drops it
  task automatic send_request(tkh_in_t req);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expect_mem[exp_wr] = predict_selection(req);
    exp_wr = exp_wr + 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_k(logic [CountW-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    keep_k = k;
  endtask

  function automatic tkh_in_t offer(logic signed [ValueW-1:0] v);
    tkh_in_t r;
    r.action = ActOffer;
    r.candidate_value = v;
    r.candidate_start = TagW'($urandom());
    r.candidate_end = TagW'($urandom());
    return r;
  endfunction

  function automatic tkh_in_t clear_req();
    tkh_in_t r;
    r = '0;
    r.action = ActClear;
    r.candidate_value = $urandom();
    r.candidate_start = TagW'($urandom());
    r.candidate_end = TagW'($urandom());
    return r;
  endfunction

  // Field extremes, reset k, rejects, equal values, clear
  task automatic test_directed();
    tkh_in_t r;
    send_request(clear_req());
    send_request(offer(32'sh7fffffff));
    send_request(offer(32'sh80000000));
    r = offer(0); r.candidate_start = '1; r.candidate_end = '1; send_request(r);
    r = offer(-1); r.candidate_start = '0; r.candidate_end = '0; send_request(r);
    send_request(offer(5));
    send_request(offer(5));
    drain();
    write_k(10'd2);
    send_request(offer(-100));
    send_request(offer(5));
    send_request(offer(32'sh80000000));
    send_request(offer(32'sh7fffffff));
    send_request(clear_req());
    send_request(offer(3));
    send_request(offer(3));
    send_request(offer(3));
    send_request(offer(4));
    drain();
  endtask

  // k of zero acts as one; lowering k below the count keeps the heap
  task automatic test_k_edges();
    int i;
    write_k(10'd0);
    for (i = 0; i < 4; i++) send_request(offer($urandom_range(0, 20) - 10));
    drain();
    write_k(10'd6);
    for (i = 0; i < 8; i++) send_request(offer($urandom_range(0, 40) - 20));
    drain();
    write_k(10'd3);
    for (i = 0; i < 6; i++) send_request(offer($urandom_range(0, 40) - 20));
    drain();
  endtask

  // Random mix at a given k, mostly offers with occasional clears
  task automatic test_random(logic [CountW-1:0] k, int n, int span);
    int i;
    write_k(k);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 60) == 0) send_request(clear_req());
      else if ($urandom_range(0, 9) == 0) send_request(offer($urandom()));
      else send_request(offer($urandom_range(0, span) - span / 2));
    end
    drain();
  endtask

  // Fill to full capacity with k beyond it; the last part runs without idling
  task automatic test_full_heap();
    int i;
    write_k(10'd1023);
    send_request(clear_req());
    for (i = 0; i < 516; i++) begin
      if (i == 456) idle_ok = 1'b0;
      send_request(offer($urandom()));
    end
    drain();
  endtask

  initial begin
    heap_size = 0;
    keep_k = CountW'(KReset);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_k_edges();
    test_random(10'd7, 20, 64);
    test_random(10'd1, 6, 16);
    test_full_heap();
    if (mismatches == 0)
      $display("top_k_min_heap_selector regression: pass");
    else
      $display("top_k_min_heap_selector regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
